// ===== design/fst_pkg.sv =====
// Shared types and constants of the flow session tracker.
package fst_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] MIN_IP_LEN     = 16'd34;
  localparam logic [15:0] MIN_TCP_LEN    = 16'd54;
  localparam logic [15:0] MIN_UDP_LEN    = 16'd42;

  localparam logic [1:0] STATUS_UPDATED = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_UNTRACKED = 2'd3;

  localparam logic CFG_FIRST_PORT  = 1'b0;
  localparam logic CFG_SECOND_PORT = 1'b1;

  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
  } flow_key_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_COMPARE, ST_UPDATE, ST_INSERT, ST_REPORT, ST_OUTPUT
  } fst_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the transaction
    logic scan_start; // reset the scan index
    logic scan_next;  // step the scan index
    logic rd_issue;   // issue a table read
    logic do_update;  // write back the incremented counters
    logic do_insert;  // append a new entry
    logic do_full;    // report table full
    logic do_untrack; // report not tracked
  } fst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tracked;
    logic scan_done;  // scan index reached the fill count
    logic hit;        // key compare against the registered table read
    logic full;
  } fst_stat_t;

endpackage

// ===== design/fst_stream_if.sv =====
// Valid/ready channel interface carrying one payload.
interface fst_stream_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/fst_ctrl.sv =====
// Controller state machine of the flow session tracker.
module fst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  input  fst_pkg::fst_stat_t  stat,
  output fst_pkg::fst_cmd_t   cmd,
  output logic                in_ready,
  output logic                res_load
);

  fst_pkg::fst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fst_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fst_pkg::ST_IDLE: if (in_fire) state_nxt = fst_pkg::ST_READ;
      fst_pkg::ST_READ: begin
        if (!stat.tracked) state_nxt = fst_pkg::ST_REPORT;
        else if (stat.scan_done) state_nxt = stat.full ? fst_pkg::ST_REPORT
                                                       : fst_pkg::ST_INSERT;
        else state_nxt = fst_pkg::ST_COMPARE;
      end
      fst_pkg::ST_COMPARE: state_nxt = stat.hit ? fst_pkg::ST_UPDATE : fst_pkg::ST_READ;
      fst_pkg::ST_UPDATE: state_nxt = fst_pkg::ST_OUTPUT;
      fst_pkg::ST_INSERT: state_nxt = fst_pkg::ST_OUTPUT;
      fst_pkg::ST_REPORT: state_nxt = fst_pkg::ST_OUTPUT;
      fst_pkg::ST_OUTPUT: if (!out_busy) state_nxt = fst_pkg::ST_IDLE;
      default: state_nxt = fst_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state_r)
      fst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        cmd.scan_start = in_fire;
      end
      fst_pkg::ST_READ: begin
        cmd.rd_issue = stat.tracked && !stat.scan_done;
        cmd.do_untrack = !stat.tracked;
        cmd.do_full = stat.tracked && stat.scan_done && stat.full;
      end
      fst_pkg::ST_COMPARE: cmd.scan_next = !stat.hit;
      fst_pkg::ST_UPDATE: cmd.do_update = 1'b1;
      fst_pkg::ST_INSERT: cmd.do_insert = 1'b1;
      fst_pkg::ST_REPORT: ;
      fst_pkg::ST_OUTPUT: res_load = !out_busy;
      default: ;
    endcase
  end

  // A new transaction is only taken while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == fst_pkg::ST_IDLE) else $error("load outside idle");
  a_update_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fst_pkg::ST_UPDATE |-> $past(stat.hit)) else $error("update without hit");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_update && cmd.do_insert)) else $error("two writes");

endmodule

// ===== design/fst_dpath.sv =====
// Datapath: transaction capture, flow table memories, scan and counters.
module fst_dpath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fst_pkg::fst_cmd_t  cmd,
  output fst_pkg::fst_stat_t stat,
  input  logic [15:0]        frame_length,
  input  logic [15:0]        ether_type,
  input  fst_pkg::flow_key_t key_in,
  input  logic [63:0]        now_ns,
  output logic [1:0]         res_status,
  output logic [63:0]        res_packets,
  output logic [63:0]        res_bytes
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  fst_pkg::flow_key_t keys_mem [TABLE_DEPTH];
  logic [63:0] pkt_mem  [TABLE_DEPTH];
  logic [63:0] byte_mem [TABLE_DEPTH];
  logic [63:0] seen_mem [TABLE_DEPTH];

  fst_pkg::flow_key_t key_r, rd_key_r;
  logic [15:0] len_r;
  logic [63:0] now_r, rd_pkt_r, rd_byte_r;
  logic        tracked_r;
  logic [CW-1:0] idx_r, used_r;
  logic [IW-1:0] idx_w, ins_w, wr_w;

  assign idx_w = idx_r[IW-1:0];
  assign ins_w = used_r[IW-1:0];
  // One write address for all table memories.
  assign wr_w = cmd.do_insert ? ins_w : idx_w;

  // Capture the transaction and qualify it for tracking.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_in;
      len_r <= frame_length;
      now_r <= now_ns;
      tracked_r <= ether_type == fst_pkg::ETHERTYPE_IPV4 &&
                   frame_length >= fst_pkg::MIN_IP_LEN &&
                   ((key_in.proto == fst_pkg::PROTO_TCP &&
                     frame_length >= fst_pkg::MIN_TCP_LEN) ||
                    (key_in.proto == fst_pkg::PROTO_UDP &&
                     frame_length >= fst_pkg::MIN_UDP_LEN));
    end
  end

  // Scan index and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.scan_start) idx_r <= '0;
      else if (cmd.scan_next) idx_r <= idx_r + 1'b1;
      if (cmd.do_insert) used_r <= used_r + 1'b1;
    end
  end

  // Registered table read; the key compare works on the read register.
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_key_r <= keys_mem[idx_w];
      rd_pkt_r <= pkt_mem[idx_w];
      rd_byte_r <= byte_mem[idx_w];
    end
  end

  // Table writes and result formation.
  always_ff @(posedge clk) begin
    if (cmd.do_update) begin
      pkt_mem[wr_w] <= rd_pkt_r + 64'd1;
      byte_mem[wr_w] <= rd_byte_r + {48'd0, len_r};
      seen_mem[wr_w] <= now_r;
      res_status <= fst_pkg::STATUS_UPDATED;
      res_packets <= rd_pkt_r + 64'd1;
      res_bytes <= rd_byte_r + {48'd0, len_r};
    end else if (cmd.do_insert) begin
      keys_mem[wr_w] <= key_r;
      pkt_mem[wr_w] <= 64'd1;
      byte_mem[wr_w] <= {48'd0, len_r};
      seen_mem[wr_w] <= now_r;
      res_status <= fst_pkg::STATUS_INSERTED;
      res_packets <= 64'd1;
      res_bytes <= {48'd0, len_r};
    end else if (cmd.do_full || cmd.do_untrack) begin
      res_status <= cmd.do_full ? fst_pkg::STATUS_FULL : fst_pkg::STATUS_UNTRACKED;
      res_packets <= '0;
      res_bytes <= '0;
    end
  end

  assign stat.tracked = tracked_r;
  assign stat.scan_done = idx_r == used_r;
  assign stat.hit = rd_key_r == key_r;
  assign stat.full = used_r == CW'(TABLE_DEPTH);

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH)) else $error("fill count overrun");
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !stat.full) else $error("insert into full table");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> idx_r < used_r) else $error("read past fill");

endmodule

// ===== design/flow_session_tracker.sv =====
// Top level of the flow session tracker.
// Usage: packet summaries arrive on the in_ channel (valid/ready); one
// result per transaction leaves on the out_ channel. Configuration writes
// (cfg_we, cfg_index, cfg_data) set the two forwarding ports; the user must
// make them while the block is idle, which the block itself does not enforce.
// A tracked packet is matched against the flow table by a sequential scan:
// each filled entry visited takes a registered read, then a key compare.
// An untracked packet is reported without a scan. A scan that passes every
// filled entry without a hit ends in an insert, or in a table-full refusal
// when the table is full; a hit on an entry updates its counters. One
// transaction is processed at a time and the idle state follows each;
// throughput is set by the scan over the table memory.
// Reset empties the table (fill count to zero) and sets the ports to 1 and 2;
// no clearing pass is needed. When the receiver stalls, the result holds in
// the output register while the next transaction is accepted and worked on;
// that one waits in its final state until the register frees.
module flow_session_tracker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  fst_stream_if.sink   in_ch,
  fst_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  // Payload layout of the input: fields from lowest bits upward.
  logic [15:0] in_frame_length, in_ether_type, in_source_port, in_destination_port;
  logic [7:0]  in_ip_protocol, in_ingress_port;
  logic [31:0] in_source_address, in_destination_address;
  logic [63:0] in_now_ns;
  assign {in_now_ns, in_ingress_port, in_destination_port, in_source_port,
          in_destination_address, in_source_address, in_ip_protocol,
          in_ether_type, in_frame_length} = in_ch.data;

  fst_pkg::fst_cmd_t  cmd;
  fst_pkg::fst_stat_t stat;
  fst_pkg::flow_key_t key_in;
  logic in_fire, in_ready, res_load, out_valid_r;
  logic [7:0] first_port_r, second_port_r, ingress_r, fwd_egress;
  logic fwd_action;
  logic [1:0] res_status, out_status_r;
  logic [63:0] res_packets, res_bytes, out_packets_r, out_bytes_r;

  assign key_in = '{saddr: in_source_address, daddr: in_destination_address,
                    sport: in_source_port, dport: in_destination_port,
                    proto: in_ip_protocol};
  assign in_ch.ready = in_ready;
  assign in_fire = in_ch.valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_port_r <= 8'd1;
      second_port_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fst_pkg::CFG_FIRST_PORT: first_port_r <= cfg_data;
        fst_pkg::CFG_SECOND_PORT: second_port_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (in_fire) ingress_r <= in_ingress_port;

  // Forwarding decision.
  always_comb begin
    fwd_action = 1'b0;
    fwd_egress = 8'd0;
    if (ingress_r == first_port_r) begin
      fwd_action = 1'b1;
      fwd_egress = second_port_r;
    end else if (ingress_r == second_port_r) begin
      fwd_action = 1'b1;
      fwd_egress = first_port_r;
    end
  end

  fst_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r && !out_ch.ready),
    .stat, .cmd, .in_ready, .res_load
  );

  fst_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk, .rst_n, .cmd, .stat,
    .frame_length(in_frame_length), .ether_type(in_ether_type), .key_in,
    .now_ns(in_now_ns), .res_status, .res_packets, .res_bytes
  );

  // Output register.
  logic out_action_r;
  logic [7:0] out_egress_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_packets_r <= res_packets;
      out_bytes_r <= res_bytes;
      out_action_r <= fwd_action;
      out_egress_r <= fwd_egress;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = {out_egress_r, out_action_r, out_bytes_r, out_packets_r,
                        out_status_r};

endmodule
